### rtl/core/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// Holds line/row layouts, op and state codes and register indexes.
// No dependencies.
package salru_pkg;

   localparam int MAX_SETS     = 1024;
   localparam int SET_IDX_W    = $clog2(MAX_SETS);
   localparam int MAX_SET_BITS = SET_IDX_W;
   localparam int MAX_WAYS     = 8;
   localparam int WAY_W        = $clog2(MAX_WAYS);
   localparam int AGE_W        = 32;
   localparam int TAG_W        = 64;
   localparam int ADDR_W       = 64;
   localparam int CNT_W        = 32;

   // configuration register widths
   localparam int SET_BITS_W   = 4;
   localparam int OFFSET_W     = 6;
   localparam int WAYS_CFG_W   = 4;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 6;
   localparam int TSHIFT_W     = 7;

   // stream payload widths
   localparam int REQ_DATA_W   = 64;
   localparam int REQ_USER_W   = 2;
   localparam int RSP_DATA_W   = 112;
   localparam int RSP_USER_W   = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SET_BITS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_BITS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WAYS        = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_STORE  = 2'd1,
      OP_MODIFY = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic             valid;
      logic [TAG_W-1:0] tag;
      logic [AGE_W-1:0] age;
   } line_type;

   typedef line_type [MAX_WAYS-1:0] row_type;

   // outcome of one lookup in a set
   typedef struct packed {
      logic             hit;
      logic             evict;
      logic [WAY_W-1:0] way;
   } lookup_type;

endpackage

### rtl/core/salru_set_logic.sv
// Lookup and LRU update of one cache set row.
// Compares tags, picks the victim and builds the row to write back.
// Depends on salru_pkg.
module salru_set_logic
   import salru_pkg::*;
(
   input  row_type                 cur_row,
   input  logic [TAG_W-1:0]        tag,
   input  logic [WAYS_CFG_W-1:0]   num_ways,
   output lookup_type              look,
   output row_type                 new_row
);

   always_comb begin
      logic             hit;
      logic [WAY_W-1:0] hit_way;
      logic [WAY_W-1:0] vic_way;
      logic [WAY_W-1:0] use_way;
      logic [AGE_W-1:0] best;

      // match tags, highest matching way wins
      hit     = 1'b0;
      hit_way = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAYS_CFG_W'(i) < num_ways && cur_row[i].valid && cur_row[i].tag == tag) begin
            hit     = 1'b1;
            hit_way = WAY_W'(i);
         end
      end

      // victim: highest-indexed way with the largest age
      best    = cur_row[0].age;
      vic_way = '0;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAYS_CFG_W'(i) < num_ways && cur_row[i].age >= best) begin
            best    = cur_row[i].age;
            vic_way = WAY_W'(i);
         end
      end

      use_way = hit ? hit_way : vic_way;

      // age every active way, then reset the used one
      new_row = cur_row;
      for (int i = 0; i < MAX_WAYS; i++) begin
         if (WAYS_CFG_W'(i) < num_ways && cur_row[i].age != {AGE_W{1'b1}}) begin
            new_row[i].age = cur_row[i].age + AGE_W'(1);
         end
      end
      new_row[use_way].age = '0;
      if (!hit) begin
         new_row[use_way].tag   = tag;
         new_row[use_way].valid = 1'b1;
      end

      look.hit   = hit;
      look.evict = !hit && cur_row[vic_way].valid;
      look.way   = use_way;
   end

endmodule

### rtl/core/set_associative_lru_cache_model.sv
// Set-associative LRU cache model. After reset the block sweeps its set memory, one
// row per cycle, before it takes the first request (configuration writes are
// taken during the sweep). A load or store then goes through an accept cycle,
// which reads the set row from the registered-read memory, and the update state
// that follows it, which compares all ways, picks the victim and writes the row back. A
// modify runs two such passes; op code 3 is accepted and gives no beat. A
// response that waits in the output register stalls the write-back cycle until
// it is taken. Depends on salru_pkg and salru_set_logic.
module set_associative_lru_cache_model
   import salru_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [REQ_DATA_W-1:0]   req_tdata,   // [63:0] addr
   input  logic [REQ_USER_W-1:0]   req_tuser,   // [1:0] op
   // response channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RSP_DATA_W-1:0]   rsp_tdata,   // [2:0] way_used, [12:3] set_used,
                                                // [44:13] hit_total, [76:45] miss_total,
                                                // [108:77] eviction_total, rest zero
   output logic [RSP_USER_W-1:0]   rsp_tuser,   // [0] hit, [1] miss, [2] eviction
   output logic                    rsp_tlast,
   // configuration write channel
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   state_type                state_ff, state_in;
   logic [SET_BITS_W-1:0]    set_bits_ff;
   logic [OFFSET_W-1:0]      offset_bits_ff;
   logic [WAYS_CFG_W-1:0]    ways_ff;
   logic [SET_IDX_W-1:0]     clr_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [SET_IDX_W-1:0]     set_ff;
   logic                     second_ff;
   logic [CNT_W-1:0]         hit_cnt_ff, miss_cnt_ff, evict_cnt_ff;
   logic [CNT_W-1:0]         hit_cnt_in, miss_cnt_in, evict_cnt_in;
   logic                     rsp_valid_ff;
   logic                     rsp_hit_ff, rsp_miss_ff, rsp_evict_ff, rsp_last_ff;
   logic [WAY_W-1:0]         rsp_way_ff;
   logic [SET_IDX_W-1:0]     rsp_set_ff;

   row_type                  ram [MAX_SETS];
   row_type                  rd_row_ff;
   row_type                  new_row;
   lookup_type               look;

   logic                     req_fire, upd_fire, rd_en, rd_from_req, clr_we;
   op_type                   req_op;
   logic [SET_BITS_W-1:0]    sb_eff;
   logic [WAYS_CFG_W-1:0]    nw_eff;
   logic [TSHIFT_W-1:0]      tshift;
   logic [TAG_W-1:0]         tag;
   logic [ADDR_W-1:0]        rd_addr_src, shifted;
   logic [SET_IDX_W-1:0]     rd_set;

   assign req_op   = op_type'(req_tuser);
   assign req_fire = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   // effective configuration
   assign sb_eff = (set_bits_ff > SET_BITS_W'(MAX_SET_BITS)) ?
                   SET_BITS_W'(MAX_SET_BITS) : set_bits_ff;
   assign nw_eff = (ways_ff == '0) ? WAYS_CFG_W'(1) :
                   (ways_ff > WAYS_CFG_W'(MAX_WAYS)) ? WAYS_CFG_W'(MAX_WAYS) : ways_ff;

   // set index of the address being read
   assign rd_addr_src = rd_from_req ? req_tdata : addr_ff;
   assign shifted     = rd_addr_src >> offset_bits_ff;
   assign rd_set      = shifted[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << sb_eff);

   // tag of the pending access
   assign tshift = TSHIFT_W'(sb_eff) + TSHIFT_W'(offset_bits_ff);
   assign tag    = (tshift >= TSHIFT_W'(ADDR_W)) ? '0 : (addr_ff >> tshift[5:0]);

   salru_set_logic u_set_logic (
      .cur_row  (rd_row_ff),
      .tag      (tag),
      .num_ways (nw_eff),
      .look     (look),
      .new_row  (new_row)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_IDX_W'(MAX_SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_fire && req_op != OP_NONE) state_in = ST_UPDATE;
         end
         ST_READ: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) state_in = second_ff ? ST_READ : ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready  = 1'b0;
      rd_en       = 1'b0;
      rd_from_req = 1'b0;
      upd_fire    = 1'b0;
      clr_we      = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_we = 1'b1;
         end
         ST_IDLE: begin
            req_tready  = 1'b1;
            rd_from_req = 1'b1;
            rd_en       = req_tvalid;
         end
         ST_READ: begin
            rd_en = 1'b1;
         end
         ST_UPDATE: begin
            upd_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            clr_we = 1'b0;
         end
      endcase
   end

   // set memory: one row per set, read registered
   always_ff @(posedge clock) begin
      if (clr_we) begin
         ram[clr_ff] <= '0;
      end else if (upd_fire) begin
         ram[set_ff] <= new_row;
      end
      if (rd_en) begin
         rd_row_ff <= ram[rd_set];
      end
   end

   // saturating counters
   always_comb begin
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      evict_cnt_in = evict_cnt_ff;
      if (look.hit && hit_cnt_ff != {CNT_W{1'b1}}) hit_cnt_in = hit_cnt_ff + CNT_W'(1);
      if (!look.hit && miss_cnt_ff != {CNT_W{1'b1}}) miss_cnt_in = miss_cnt_ff + CNT_W'(1);
      if (look.evict && evict_cnt_ff != {CNT_W{1'b1}}) begin
         evict_cnt_in = evict_cnt_ff + CNT_W'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_ff         <= '0;
         second_ff      <= 1'b0;
         set_bits_ff    <= SET_BITS_W'(1);
         offset_bits_ff <= OFFSET_W'(4);
         ways_ff        <= WAYS_CFG_W'(1);
         hit_cnt_ff     <= '0;
         miss_cnt_ff    <= '0;
         evict_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (clr_we) clr_ff <= clr_ff + SET_IDX_W'(1);

         // take register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SET_BITS:    set_bits_ff    <= csr_data[SET_BITS_W-1:0];
               CSR_OFFSET_BITS: offset_bits_ff <= csr_data[OFFSET_W-1:0];
               CSR_WAYS:        ways_ff        <= csr_data[WAYS_CFG_W-1:0];
               default:         set_bits_ff    <= set_bits_ff;
            endcase
         end

         if (req_fire) second_ff <= (req_op == OP_MODIFY);
         else if (upd_fire) second_ff <= 1'b0;

         if (upd_fire) begin
            hit_cnt_ff   <= hit_cnt_in;
            miss_cnt_ff  <= miss_cnt_in;
            evict_cnt_ff <= evict_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) addr_ff <= req_tdata;
      if (rd_en) set_ff <= rd_set;
      if (upd_fire) begin
         rsp_hit_ff   <= look.hit;
         rsp_miss_ff  <= !look.hit;
         rsp_evict_ff <= look.evict;
         rsp_way_ff   <= look.way;
         rsp_set_ff   <= set_ff;
         rsp_last_ff  <= !second_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_evict_ff, rsp_miss_ff, rsp_hit_ff};
   assign rsp_tdata  = {3'b000, evict_cnt_ff, miss_cnt_ff, hit_cnt_ff, rsp_set_ff, rsp_way_ff};

`ifndef SYNTHESIS
   // a modify's first pass goes back for a second read
   a_second_pass: assert property (@(posedge clock) disable iff (reset)
      (upd_fire && second_ff) |=> (state_ff == ST_READ))
      else $error("modify did not start its second pass");

   // every delivered beat is either a hit or a miss
   a_hit_xor_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_hit_ff ^ rsp_miss_ff))
      else $error("response is not exactly one of hit and miss");

   // an eviction only comes with a miss
   a_evict_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_evict_ff) |-> rsp_miss_ff)
      else $error("eviction without miss");

   // running totals never go down
   a_cnt_mono: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (hit_cnt_ff >= $past(hit_cnt_ff) && miss_cnt_ff >= $past(miss_cnt_ff)
                && evict_cnt_ff >= $past(evict_cnt_ff)))
      else $error("counter decreased");

   // no request is taken during the clearing sweep
   a_no_req_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !(req_fire || upd_fire))
      else $error("access during clearing sweep");
`endif

endmodule
